// ===== hdl/gedr_pkg.sv =====
// ---------------------------------------------------------------------------
// gedr_pkg
// Shared types and constants for the gyro/encoder dead-reckoning unit.
// ---------------------------------------------------------------------------
package gedr_pkg;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_GYRO = 2'd1;
    localparam logic [1:0] FUNC_POS  = 2'd2;

    localparam logic CFG_SAMPLE_PERIOD = 1'b0;
    localparam logic CFG_MM_PER_TICK   = 1'b1;

    localparam logic signed [31:0] TWO_PI_Q16  = 32'sd411775;
    localparam logic signed [31:0] PI_Q16      = 32'sd205887;
    localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam int ATAN_LEN = 24;

    // reciprocal of 2*pi in Q16.16, rounded up; exact quotient for |heading| <= 2^31
    localparam int          RECIP_SHIFT  = 50;
    localparam int          QUOT_W       = 13;
    localparam logic [31:0] TWO_PI_RECIP =
        32'(((64'd1 << RECIP_SHIFT) + 64'd411774) / 64'd411775);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WRAP,
        ST_REDUCE,
        ST_CORDIC,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } gedr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic exec;       // tick / gyro / distance, heading quotient
        logic wrap;       // heading remainder, wrap into +-pi
        logic reduce;     // fold heading into +-pi/2
        logic cordic;     // one rotation step
        logic mul;        // dist * cos / sin
        logic acc;        // update x/y
    } gedr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pos;
        logic cordic_done;
    } gedr_sts_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 34'h03243F6A8;
            5'd1:  atan_q30 = 34'h01DAC6705;
            5'd2:  atan_q30 = 34'h00FADBAFC;
            5'd3:  atan_q30 = 34'h007F56EA6;
            5'd4:  atan_q30 = 34'h003FEAB76;
            5'd5:  atan_q30 = 34'h001FFD55B;
            5'd6:  atan_q30 = 34'h000FFFAAA;
            5'd7:  atan_q30 = 34'h0007FFF55;
            5'd8:  atan_q30 = 34'h0003FFFEA;
            5'd9:  atan_q30 = 34'h0001FFFFD;
            5'd10: atan_q30 = 34'h0000FFFFF;
            5'd11: atan_q30 = 34'h00007FFFF;
            5'd12: atan_q30 = 34'h00003FFFF;
            5'd13: atan_q30 = 34'h00001FFFF;
            5'd14: atan_q30 = 34'h00000FFFF;
            5'd15: atan_q30 = 34'h000007FFF;
            5'd16: atan_q30 = 34'h000003FFF;
            5'd17: atan_q30 = 34'h000001FFF;
            5'd18: atan_q30 = 34'h000000FFF;
            5'd19: atan_q30 = 34'h0000007FF;
            5'd20: atan_q30 = 34'h0000003FF;
            5'd21: atan_q30 = 34'h0000001FF;
            5'd22: atan_q30 = 34'h0000000FF;
            5'd23: atan_q30 = 34'h00000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            sat32 = 32'h7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            sat32 = 32'h80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== hdl/gedr_ctrl.sv =====
// ---------------------------------------------------------------------------
// gedr_ctrl
// Sequencer: execute, CORDIC for position items only, then output hand-off.
// ---------------------------------------------------------------------------
module gedr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic                  out_fire,
    input  gedr_pkg::gedr_sts_t   sts,
    output gedr_pkg::gedr_cmd_t   cmd,
    output logic                  in_ready,
    output logic                  out_valid
);
    import gedr_pkg::*;

    gedr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_EXEC;
            ST_EXEC:   state_next = sts.is_pos ? ST_WRAP : ST_OUT;
            ST_WRAP:   state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_CORDIC;
            ST_CORDIC: if (sts.cordic_done) state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = ST_OUT;
            ST_OUT:    if (out_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_EXEC:   cmd.exec   = 1'b1;
            ST_WRAP:   cmd.wrap   = 1'b1;
            ST_REDUCE: cmd.reduce = 1'b1;
            ST_CORDIC: cmd.cordic = 1'b1;
            ST_MUL:    cmd.mul    = 1'b1;
            ST_ACC:    cmd.acc    = 1'b1;
            ST_OUT:    out_valid  = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hdl/gedr_dp.sv =====
// ---------------------------------------------------------------------------
// gedr_dp
// Datapath: tick counter, heading integrator, angle reduction, iterative
// CORDIC and saturating position accumulators.
// ---------------------------------------------------------------------------
module gedr_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gedr_pkg::gedr_cmd_t   cmd,
    output gedr_pkg::gedr_sts_t   sts,
    input  logic [1:0]            func,
    input  logic signed [15:0]    yaw_rate,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic                  cfg_index_ok,
    input  logic [15:0]           cfg_data,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic signed [31:0]    heading_angle
);
    import gedr_pkg::*;

    localparam int RUN_STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    logic [15:0]        period_reg, mmpt_reg;
    logic [15:0]        tick_reg, last_tick_reg;
    logic signed [15:0] prev_rate_reg;
    logic signed [31:0] heading_reg, x_reg, y_reg;
    logic [1:0]         func_reg;
    logic signed [15:0] rate_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic signed [31:0] r_reg;
    logic               neg_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]         step_reg;
    logic [31:0]        dist_reg;
    logic signed [66:0] px_reg, py_reg;

    // gyro increment
    logic signed [16:0] rate_sum;
    logic signed [34:0] gyro_prod;
    logic signed [34:0] gyro_inc;
    assign rate_sum  = 17'(prev_rate_reg) + 17'(rate_reg);
    assign gyro_prod = 35'(rate_sum) * $signed({19'd0, period_reg}) + 35'sd4096;
    assign gyro_inc  = gyro_prod >>> 13;

    // heading mod 2*pi (truncating) by reciprocal multiply, then wrap into [-pi, pi]
    logic [31:0]        head_mag;
    logic [63:0]        recip_prod;
    logic [31:0]        wrap_mag;
    logic signed [31:0] rem_q;
    logic signed [31:0] r_wrap;
    assign head_mag   = heading_reg[31] ? $unsigned(-heading_reg) : $unsigned(heading_reg);
    assign recip_prod = 64'(head_mag) * 64'(TWO_PI_RECIP);
    assign wrap_mag   = head_mag - 32'(quot_reg) * $unsigned(TWO_PI_Q16);
    always_comb begin
        rem_q  = heading_reg[31] ? -$signed(wrap_mag) : $signed(wrap_mag);
        r_wrap = (rem_q < 0) ? rem_q + TWO_PI_Q16 : rem_q;
        if (r_wrap > PI_Q16) r_wrap = r_wrap - TWO_PI_Q16;
    end

    logic signed [33:0] xs, ys, atan_v;
    assign xs     = cx_reg >>> step_reg;
    assign ys     = cy_reg >>> step_reg;
    assign atan_v = atan_q30(step_reg);

    logic signed [34:0] x_sum, y_sum;
    assign x_sum = 35'(x_reg) + 35'(px_reg >>> 30);
    assign y_sum = 35'(y_reg) + 35'(py_reg >>> 30);

    assign sts.is_pos      = (func_reg == FUNC_POS);
    assign sts.cordic_done = (step_reg == 5'(RUN_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= 16'd6554;
            mmpt_reg      <= 16'd1070;
            tick_reg      <= '0;
            last_tick_reg <= '0;
            prev_rate_reg <= '0;
            heading_reg   <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
        end else begin
            if (cfg_we && cfg_index_ok) begin
                if (cfg_index == CFG_SAMPLE_PERIOD) period_reg <= cfg_data;
                else                                mmpt_reg   <= cfg_data;
            end
            if (cmd.exec) begin
                case (func_reg)
                    FUNC_TICK: tick_reg <= tick_reg + 16'd1;
                    FUNC_GYRO: begin
                        heading_reg   <= sat32(35'(heading_reg) + gyro_inc);
                        prev_rate_reg <= rate_reg;
                    end
                    FUNC_POS: begin
                        dist_reg      <= 32'(16'(tick_reg - last_tick_reg)) * 32'(mmpt_reg);
                        last_tick_reg <= tick_reg;
                    end
                    default: ;
                endcase
            end
            if (cmd.acc) begin
                x_reg <= sat32(x_sum);
                y_reg <= sat32(y_sum);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func;
            rate_reg <= yaw_rate;
        end
        if (cmd.exec) begin
            quot_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (cmd.wrap) begin
            r_reg <= r_wrap;
        end
        if (cmd.reduce) begin
            neg_reg  <= (r_reg > HALF_PI_Q16) || (r_reg < -HALF_PI_Q16);
            step_reg <= '0;
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            if (r_reg > HALF_PI_Q16) begin
                cz_reg  <= 34'(r_reg - PI_Q16) <<< 14;
            end else if (r_reg < -HALF_PI_Q16) begin
                cz_reg  <= 34'(r_reg + PI_Q16) <<< 14;
            end else begin
                cz_reg  <= 34'(r_reg) <<< 14;
            end
        end
        if (cmd.cordic) begin
            step_reg <= step_reg + 5'd1;
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.mul) begin
            px_reg <= $signed({1'b0, dist_reg}) * (neg_reg ? -cx_reg : cx_reg)
                      + 67'sd536870912;
            py_reg <= $signed({1'b0, dist_reg}) * (neg_reg ? -cy_reg : cy_reg)
                      + 67'sd536870912;
        end
    end

    assign pos_x         = x_reg;
    assign pos_y         = y_reg;
    assign heading_angle = heading_reg;

endmodule

// ===== hdl/gyro_encoder_dead_reckoning_unit.sv =====
// ---------------------------------------------------------------------------
// gyro_encoder_dead_reckoning_unit
// Dead reckoning from wheel-encoder ticks and a yaw-rate gyro.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis: one event per item; tdata = {yaw_rate[17:2], func[1:0]}.
//     func 0 counts a tick, 1 integrates a gyro rate, 2 updates position.
//   m_axis: one item per event with x, y (Q24.8 mm) and heading (Q16.16 rad).
//   cfg: write enable, index 0 sample_period, 1 mm_per_tick; write only
//     while idle.
// Sequence: tick and gyro events go from accept through execute to output;
//   position updates go through execute, wrap, reduce, the iterative
//   CORDIC (N = min(CORDIC_STEPS, 24) rotations, one rotation per cycle),
//   multiply and accumulate before output.
// One item is in flight at a time; s_axis_tready is high only when idle.
// Reset clears state, counters and positions and loads default registers.
// A stalled m_axis holds its item and blocks new input until taken.
// ---------------------------------------------------------------------------
module gyro_encoder_dead_reckoning_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // func[1:0], yaw_rate[17:2], zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // pos_x, pos_y, heading_angle
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import gedr_pkg::*;

    gedr_cmd_t cmd;
    gedr_sts_t sts;
    logic signed [31:0] pos_x, pos_y, heading_angle;
    logic in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    gedr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    gedr_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .func          (s_axis_tdata[1:0]),
        .yaw_rate      (s_axis_tdata[17:2]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index[0]),
        .cfg_index_ok  (1'b1),
        .cfg_data      (cfg_data),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading_angle (heading_angle)
    );

    assign m_axis_tdata = {heading_angle, pos_y, pos_x};

endmodule
